// ===== rtl/core/flpw_pkg.sv =====
// Shared types, constants and helpers for the four-level page walker.
// No dependencies; every other file in rtl/core uses this package.
package flpw_pkg;

  // Implemented physical address width (36..52); port fields stay 52 bits.
  localparam int unsigned PA_BITS   = 52;
  localparam int unsigned PA_W      = 52;
  localparam int unsigned VA_W      = 48;
  localparam int unsigned ENTRY_W   = 64;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned SHIFT_4K  = 12;
  localparam int unsigned SHIFT_2M  = 21;
  localparam int unsigned SHIFT_1G  = 30;

  // Address masks, all PA_W bits wide.
  localparam logic [PA_W-1:0] PaMask  = {PA_W{1'b1}} >> (PA_W - PA_BITS);
  localparam logic [PA_W-1:0] Base4k  = PaMask & ~((PA_W'(1) << SHIFT_4K) - PA_W'(1));
  localparam logic [PA_W-1:0] Base2m  = PaMask & ~((PA_W'(1) << SHIFT_2M) - PA_W'(1));
  localparam logic [PA_W-1:0] Base1g  = PaMask & ~((PA_W'(1) << SHIFT_1G) - PA_W'(1));

  // Entry flag bit positions.
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_LARGE   = 7;

  // Table levels, top table first.
  localparam logic [1:0] LVL_0 = 2'd0;
  localparam logic [1:0] LVL_1 = 2'd1;
  localparam logic [1:0] LVL_2 = 2'd2;
  localparam logic [1:0] LVL_3 = 2'd3;

  // Page size codes.
  localparam logic [1:0] PAGE_4K = 2'd0;
  localparam logic [1:0] PAGE_2M = 2'd1;
  localparam logic [1:0] PAGE_1G = 2'd2;

  // Input item function codes.
  typedef enum logic {
    KIND_REQ  = 1'b0,
    KIND_DATA = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [0:0]         func;
    logic [ENTRY_W-1:0] table_root;
    logic [VA_W-1:0]    lin_addr;
    logic [ENTRY_W-1:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic            read_request;
    logic [PA_W-1:0] read_addr;
    logic            done_res;
    logic            fault;
    logic [1:0]      fault_level;
    logic [PA_W-1:0] xlat_addr;
    logic [1:0]      page_size;
  } out_item_t;

  // Classified item as it sits in the queue between front and back.
  // For a request, word holds the first entry address; for data, the entry.
  typedef struct packed {
    item_kind_e         kind;
    logic [VA_W-1:0]    vaddr;
    logic [ENTRY_W-1:0] word;
  } q_item_t;

  // Table index of a virtual address at a level.
  function automatic logic [IDX_W-1:0] table_index(logic [VA_W-1:0] va, logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LVL_0:   idx = va[47:39];
      LVL_1:   idx = va[38:30];
      LVL_2:   idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  // Entry address: table base plus index times eight (base is 4KB aligned).
  function automatic logic [PA_W-1:0] entry_addr(logic [PA_W-1:0] base,
                                                logic [IDX_W-1:0] idx);
    return (base & Base4k) | {{(PA_W-IDX_W-3){1'b0}}, idx, 3'b000};
  endfunction

endpackage

// ===== rtl/core/flpw_front.sv =====
// Front end of the page walker: accepts input items and classifies them.
// Uses flpw_pkg; feeds flpw_queue.
module flpw_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  flpw_pkg::in_item_t in_item_i,
  input  logic               q_full_i,
  output logic               push_o,
  output flpw_pkg::q_item_t  push_item_o
);

  logic [flpw_pkg::PA_W-1:0] first_addr;

  // Top-table entry address for a new request
  assign first_addr = flpw_pkg::entry_addr(
      in_item_i.table_root[flpw_pkg::PA_W-1:0],
      flpw_pkg::table_index(in_item_i.lin_addr, flpw_pkg::LVL_0));

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify: requests carry their first read address, data carries the entry
  always_comb begin
    push_item_o.vaddr = in_item_i.lin_addr;
    if (in_item_i.func == flpw_pkg::KIND_REQ) begin
      push_item_o.kind = flpw_pkg::KIND_REQ;
      push_item_o.word = {{(flpw_pkg::ENTRY_W-flpw_pkg::PA_W){1'b0}}, first_addr};
    end else begin
      push_item_o.kind = flpw_pkg::KIND_DATA;
      push_item_o.word = in_item_i.read_data;
    end
  end

endmodule

// ===== rtl/core/flpw_queue.sv =====
// Two-entry queue between the walker front and back ends.
// Uses flpw_pkg for the queued item type.
module flpw_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  flpw_pkg::q_item_t push_item_i,
  output logic              full_o,
  output logic              head_valid_o,
  output flpw_pkg::q_item_t head_o,
  input  logic              pop_i
);

  flpw_pkg::q_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/core/flpw_back.sv =====
// Back end of the page walker: walk state, entry checks and result register.
// Uses flpw_pkg; takes items from flpw_queue.
module flpw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  flpw_pkg::q_item_t   head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output flpw_pkg::out_item_t out_item_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_L0   = 5'b00010,
    ST_L1   = 5'b00100,
    ST_L2   = 5'b01000,
    ST_L3   = 5'b10000
  } walk_state_e;

  walk_state_e               state_q, state_d;
  logic [flpw_pkg::VA_W-1:0] vaddr_q, vaddr_d;
  logic                      out_valid_q;
  flpw_pkg::out_item_t       out_q;
  flpw_pkg::out_item_t       res;
  logic                      res_valid;
  logic                      back_ready;
  logic [1:0]                cur_lvl;
  logic [1:0]                next_lvl;
  walk_state_e               next_st;
  logic [flpw_pkg::PA_W-1:0] entry;
  logic                      present;
  logic                      big_page;

  assign back_ready = !out_valid_q || !out_stall_i;
  assign pop_o      = head_valid_i && back_ready;
  assign entry      = head_i.word[flpw_pkg::PA_W-1:0];
  assign present    = head_i.word[flpw_pkg::BIT_PRESENT];
  assign big_page   = head_i.word[flpw_pkg::BIT_LARGE];

  // Current level and the state for the next table
  always_comb begin
    unique case (state_q)
      ST_L0:   begin cur_lvl = flpw_pkg::LVL_0; next_lvl = flpw_pkg::LVL_1; next_st = ST_L1; end
      ST_L1:   begin cur_lvl = flpw_pkg::LVL_1; next_lvl = flpw_pkg::LVL_2; next_st = ST_L2; end
      ST_L2:   begin cur_lvl = flpw_pkg::LVL_2; next_lvl = flpw_pkg::LVL_3; next_st = ST_L3; end
      ST_L3:   begin cur_lvl = flpw_pkg::LVL_3; next_lvl = flpw_pkg::LVL_3; next_st = ST_IDLE; end
      default: begin cur_lvl = flpw_pkg::LVL_0; next_lvl = flpw_pkg::LVL_0; next_st = ST_IDLE; end
    endcase
  end

  // Walk step for the item at the queue head
  always_comb begin
    state_d   = state_q;
    vaddr_d   = vaddr_q;
    res       = '0;
    res_valid = 1'b0;
    if (head_i.kind == flpw_pkg::KIND_REQ) begin
      // new request drops any walk in progress
      state_d          = ST_L0;
      vaddr_d          = head_i.vaddr;
      res_valid        = 1'b1;
      res.read_request = 1'b1;
      res.read_addr    = entry;
    end else if (state_q != ST_IDLE) begin
      res_valid = 1'b1;
      if (!present) begin
        state_d         = ST_IDLE;
        res.done_res    = 1'b1;
        res.fault       = 1'b1;
        res.fault_level = cur_lvl;
      end else if (cur_lvl == flpw_pkg::LVL_1 && big_page) begin
        state_d       = ST_IDLE;
        res.done_res  = 1'b1;
        res.xlat_addr = (entry & flpw_pkg::Base1g) |
                        {{(flpw_pkg::PA_W-flpw_pkg::SHIFT_1G){1'b0}},
                         vaddr_q[flpw_pkg::SHIFT_1G-1:0]};
        res.page_size = flpw_pkg::PAGE_1G;
      end else if (cur_lvl == flpw_pkg::LVL_2 && big_page) begin
        state_d       = ST_IDLE;
        res.done_res  = 1'b1;
        res.xlat_addr = (entry & flpw_pkg::Base2m) |
                        {{(flpw_pkg::PA_W-flpw_pkg::SHIFT_2M){1'b0}},
                         vaddr_q[flpw_pkg::SHIFT_2M-1:0]};
        res.page_size = flpw_pkg::PAGE_2M;
      end else if (cur_lvl == flpw_pkg::LVL_3) begin
        state_d       = ST_IDLE;
        res.done_res  = 1'b1;
        res.xlat_addr = (entry & flpw_pkg::Base4k) |
                        {{(flpw_pkg::PA_W-flpw_pkg::SHIFT_4K){1'b0}},
                         vaddr_q[flpw_pkg::SHIFT_4K-1:0]};
        res.page_size = flpw_pkg::PAGE_4K;
      end else begin
        state_d          = next_st;
        res.read_request = 1'b1;
        res.read_addr    = flpw_pkg::entry_addr(entry,
                             flpw_pkg::table_index(vaddr_q, next_lvl));
      end
    end
  end

  // Walk state, advanced once per consumed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vaddr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        state_q <= state_d;
        vaddr_q <= vaddr_d;
      end
      if (back_ready) begin
        out_valid_q <= pop_o && res_valid;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (pop_o && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_req_xor_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q |-> !(out_q.read_request && out_q.done_res))
    else $error("result both requests a read and finishes the walk");

  a_fault_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && out_q.fault) |-> (out_q.done_res && out_q.xlat_addr == '0))
    else $error("faulting result carries a translation");

  a_req_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (pop_o && head_i.kind == flpw_pkg::KIND_REQ) |=> (state_q == ST_L0))
    else $error("request did not restart the walk at the top table");

  a_result_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> $past(pop_o))
    else $error("result appeared without a consumed item");
`endif

endmodule

// ===== rtl/core/four_level_page_table_walk.sv =====
// Four-level page walker, top level: front end, item queue and back end.
// Uses flpw_pkg, flpw_front, flpw_queue and flpw_back.
//
// Translates 48-bit virtual addresses through four levels of 8-byte table
// entries. A request item (func 0) yields one read request for the top-table
// entry; each returned entry (func 1) yields either the next read request or
// a finished result with the physical address and page size (4KB, 2MB, 1GB),
// or a fault with the level that was not present. A data item while no walk
// is active gives no result; a request during a walk restarts it. One item is
// accepted per cycle while the queue is not full: the front end classifies
// items into a two-entry queue and the back end handles one queued item per
// cycle unless a result is stalled, loading its result into the output
// register at the edge where it leaves the queue. With no stalls an item is
// registered in the queue, then its result in the output register. The
// input stalls only once the queue holds two items, when the output stalls.
module four_level_page_table_walk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  flpw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output flpw_pkg::out_item_t out_item_o
);

  logic              q_full;
  logic              push;
  flpw_pkg::q_item_t push_item;
  logic              head_valid;
  flpw_pkg::q_item_t head;
  logic              pop;

  flpw_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  flpw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  flpw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule
